/* hw/rtl/c2p_pkg.sv */
// Shared types, constants and the arctangent table for the cartesian to polar block.
// No dependencies; every other file in hw/rtl uses it by scoped names.
`default_nettype none

package c2p_pkg;

    // Number of CORDIC rotation cells (8 to 32)
    localparam int CORDIC_STAGES = 16;
    // Fraction bits of the range register format
    localparam int FRACTION_BITS = 16;
    // Reset value of min_range: round(0.0001 * 2^FRACTION_BITS)
    localparam int MIN_RANGE_RESET = ((1 << FRACTION_BITS) + 5000) / 10000;

    localparam int MIN_RANGE_W  = 17;
    localparam int CORDIC_GUARD = 16;
    localparam int CX_W         = 50;
    localparam int Z_W          = 36;
    localparam int SQRT_STAGES  = 32;
    localparam int QUOT_W       = 34;
    localparam int DIV_STAGES   = QUOT_W;
    localparam int STAGE_W      = 5;
    localparam int SHIFT_W      = 6;
    localparam int BEARING_MAX  = 25736;
    localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } c2p_in_t;

    typedef struct packed {
        logic        [31:0] range;
        logic signed [15:0] bearing;
        logic signed [31:0] range_rate;
        logic               rate_saturated;
    } c2p_out_t;

    // Word that travels down the row of cells
    typedef struct packed {
        logic        [63:0]       rem;
        logic        [63:0]       root;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [Z_W-1:0]    z;
        logic                     origin;
        logic        [63:0]       dot;
        logic                     neg;
        logic        [31:0]       divisor;
        logic        [QUOT_W-1:0] quot;
    } c2p_pipe_t;

    // atan(2^-i) * 2^30, truncated for i up to 26 and rounded above
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/c2p_front.sv */
// Front end: magnitudes, four 32x32 products, then sums and CORDIC start vector.
// Depends on c2p_pkg.
`default_nettype none

module c2p_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  c2p_pkg::c2p_in_t   in_data,
    output logic               out_valid,
    output c2p_pkg::c2p_pipe_t out_data
);

    logic [31:0] ax, ay, avx, avy;
    logic [63:0] pxx_reg, pyy_reg, m1_reg, m2_reg;
    logic        n1_reg, n2_reg, a_valid_reg;
    logic signed [c2p_pkg::CX_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [c2p_pkg::Z_W-1:0]  z_reg, z_next;
    logic        origin_reg;
    logic        b_valid_reg;
    c2p_pkg::c2p_pipe_t b_data_reg, b_data_next;
    logic signed [c2p_pkg::CX_W-1:0] px_e, py_e;

    // Take magnitudes of the inputs
    assign ax  = in_data.pos_x[31] ? 32'(-in_data.pos_x) : 32'(in_data.pos_x);
    assign ay  = in_data.pos_y[31] ? 32'(-in_data.pos_y) : 32'(in_data.pos_y);
    assign avx = in_data.vel_x[31] ? 32'(-in_data.vel_x) : 32'(in_data.vel_x);
    assign avy = in_data.vel_y[31] ? 32'(-in_data.vel_y) : 32'(in_data.vel_y);

    // Rotate left half plane by pi, scale by the guard bits
    always_comb
    begin
        px_e = c2p_pkg::CX_W'(in_data.pos_x);
        py_e = c2p_pkg::CX_W'(in_data.pos_y);
        if (in_data.pos_x[31])
        begin
            cx_next = (-px_e) <<< c2p_pkg::CORDIC_GUARD;
            cy_next = (-py_e) <<< c2p_pkg::CORDIC_GUARD;
            z_next  = in_data.pos_y[31] ? -c2p_pkg::PI_Q30 : c2p_pkg::PI_Q30;
        end
        else
        begin
            cx_next = px_e <<< c2p_pkg::CORDIC_GUARD;
            cy_next = py_e <<< c2p_pkg::CORDIC_GUARD;
            z_next  = '0;
        end
    end

    // Register the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pxx_reg    <= ax * ax;
            pyy_reg    <= ay * ay;
            m1_reg     <= ax * avx;
            m2_reg     <= ay * avy;
            n1_reg     <= in_data.pos_x[31] != in_data.vel_x[31];
            n2_reg     <= in_data.pos_y[31] != in_data.vel_y[31];
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            z_reg      <= z_next;
            origin_reg <= (in_data.pos_x == '0) && (in_data.pos_y == '0);
        end
    end

    // Form the sum of squares and the signed dot product magnitude
    always_comb
    begin
        b_data_next         = '0;
        b_data_next.rem     = pxx_reg + pyy_reg;
        b_data_next.cx      = cx_reg;
        b_data_next.cy      = cy_reg;
        b_data_next.z       = z_reg;
        b_data_next.origin  = origin_reg;
        if (n1_reg == n2_reg)
        begin
            b_data_next.dot = m1_reg + m2_reg;
            b_data_next.neg = n1_reg;
        end
        else if (m1_reg >= m2_reg)
        begin
            b_data_next.dot = m1_reg - m2_reg;
            b_data_next.neg = n1_reg;
        end
        else
        begin
            b_data_next.dot = m2_reg - m1_reg;
            b_data_next.neg = n2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (advance)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/c2p_cordic_cell.sv */
// One vectoring CORDIC rotation cell with its output register.
// Depends on c2p_pkg.
`default_nettype none

module c2p_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [c2p_pkg::STAGE_W-1:0]   stage,
    input  logic                          in_valid,
    input  c2p_pkg::c2p_pipe_t            in_data,
    output logic                          out_valid,
    output c2p_pkg::c2p_pipe_t            out_data
);

    logic signed [c2p_pkg::CX_W-1:0] dx, dy;
    logic signed [c2p_pkg::Z_W-1:0]  angle;
    logic                            valid_reg;
    c2p_pkg::c2p_pipe_t              data_reg, data_next;

    assign dx    = in_data.cy >>> stage;
    assign dy    = in_data.cx >>> stage;
    assign angle = c2p_pkg::atan_q30(stage);

    // Rotate toward the x axis
    always_comb
    begin
        data_next = in_data;
        if (in_data.cy > 0)
        begin
            data_next.cx = in_data.cx + dx;
            data_next.cy = in_data.cy - dy;
            data_next.z  = in_data.z + angle;
        end
        else
        begin
            data_next.cx = in_data.cx - dx;
            data_next.cy = in_data.cy + dy;
            data_next.z  = in_data.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/c2p_sqrt_cell.sv */
// One digit-pair step of the restoring integer square root, registered.
// Depends on c2p_pkg.
`default_nettype none

module c2p_sqrt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [c2p_pkg::STAGE_W-1:0]   stage,
    input  logic                          in_valid,
    input  c2p_pkg::c2p_pipe_t            in_data,
    output logic                          out_valid,
    output c2p_pkg::c2p_pipe_t            out_data
);

    logic [63:0] one_bit, trial;
    logic        valid_reg;
    c2p_pkg::c2p_pipe_t data_reg, data_next;

    assign one_bit = 64'd1 << (6'd62 - {stage, 1'b0});
    assign trial   = in_data.root + one_bit;

    // Subtract the trial value where it fits
    always_comb
    begin
        data_next = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + one_bit;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/c2p_div_cell.sv */
// One quotient bit of the restoring range rate division, registered.
// Depends on c2p_pkg.
`default_nettype none

module c2p_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [c2p_pkg::SHIFT_W-1:0]   shift,
    input  logic                          in_valid,
    input  c2p_pkg::c2p_pipe_t            in_data,
    output logic                          out_valid,
    output c2p_pkg::c2p_pipe_t            out_data
);

    logic [65:0] rem_w, dsh, diff;
    logic        valid_reg;
    c2p_pkg::c2p_pipe_t data_reg, data_next;

    assign rem_w = {2'b00, in_data.dot};
    assign dsh   = {34'd0, in_data.divisor} << shift;
    assign diff  = rem_w - dsh;

    // Subtract the shifted divisor and set the quotient bit
    always_comb
    begin
        data_next = in_data;
        if (rem_w >= dsh)
        begin
            data_next.dot  = diff[63:0];
            data_next.quot = in_data.quot | (c2p_pkg::QUOT_W'(1) << shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/cartesian_to_polar_measurement.sv */
// Throughput: one item per cycle; the whole row of cells advances together and
// halts only while the output register holds an item that is not taken.
// Reset: asynchronous, active low; clears all valid bits and loads min_range
// with 7. Depends on c2p_pkg and the front, CORDIC, square root and divide cells.
`default_nettype none

module cartesian_to_polar_measurement (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  c2p_pkg::c2p_in_t                     in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output c2p_pkg::c2p_out_t                    out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [c2p_pkg::MIN_RANGE_W-1:0]      cfg_data
);

    localparam int NC = c2p_pkg::CORDIC_STAGES;
    localparam int NS = c2p_pkg::SQRT_STAGES;
    localparam int ND = c2p_pkg::DIV_STAGES;

    logic advance;
    logic [c2p_pkg::MIN_RANGE_W-1:0] min_range_reg, min_eff;

    logic               c_valid [NC+1];
    c2p_pkg::c2p_pipe_t c_data  [NC+1];
    logic               s_valid [NS+1];
    c2p_pkg::c2p_pipe_t s_data  [NS+1];
    logic               d_valid [ND+1];
    c2p_pkg::c2p_pipe_t d_data  [ND+1];

    logic               clamp_valid_reg;
    c2p_pkg::c2p_pipe_t clamp_data_reg, clamp_data_next;
    logic               out_valid_reg;
    c2p_pkg::c2p_out_t  out_item_reg, out_item_next;

    logic signed [c2p_pkg::Z_W-1:0] z_round;
    logic [c2p_pkg::QUOT_W-1:0]     q;

    // Advance the row whenever the output register is free or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    // Hold the minimum range register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_range_reg <= c2p_pkg::MIN_RANGE_W'(c2p_pkg::MIN_RANGE_RESET);
        else if (cfg_valid)
            min_range_reg <= cfg_data;
    end

    assign min_eff = (min_range_reg == '0) ? c2p_pkg::MIN_RANGE_W'(1) : min_range_reg;

    c2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_data   (in_item),
        .out_valid (c_valid[0]),
        .out_data  (c_data[0])
    );

    // Bearing chain
    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        c2p_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage     (c2p_pkg::STAGE_W'(i)),
            .in_valid  (c_valid[i]),
            .in_data   (c_data[i]),
            .out_valid (c_valid[i+1]),
            .out_data  (c_data[i+1])
        );
    end

    assign s_valid[0] = c_valid[NC];
    assign s_data[0]  = c_data[NC];

    // Range chain
    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        c2p_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage     (c2p_pkg::STAGE_W'(i)),
            .in_valid  (s_valid[i]),
            .in_data   (s_data[i]),
            .out_valid (s_valid[i+1]),
            .out_data  (s_data[i+1])
        );
    end

    // Raise the divisor to the minimum range
    always_comb
    begin
        clamp_data_next = s_data[NS];
        if (s_data[NS].root[31:0] > {15'd0, min_eff})
            clamp_data_next.divisor = s_data[NS].root[31:0];
        else
            clamp_data_next.divisor = {15'd0, min_eff};
        clamp_data_next.quot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_valid_reg <= 1'b0;
        else if (advance)
            clamp_valid_reg <= s_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            clamp_data_reg <= clamp_data_next;
    end

    assign d_valid[0] = clamp_valid_reg;
    assign d_data[0]  = clamp_data_reg;

    // Range rate chain, top quotient bit first
    for (genvar i = 0; i < ND; i++)
    begin : g_div
        c2p_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .shift     (c2p_pkg::SHIFT_W'(ND - 1 - i)),
            .in_valid  (d_valid[i]),
            .in_data   (d_data[i]),
            .out_valid (d_valid[i+1]),
            .out_data  (d_data[i+1])
        );
    end

    // Round and clamp the bearing (zero at the origin), saturate the range rate
    assign z_round = (d_data[ND].z + c2p_pkg::Z_W'(65536)) >>> 17;
    assign q       = d_data[ND].quot;

    always_comb
    begin
        out_item_next.range = d_data[ND].root[31:0];
        if (d_data[ND].origin)
            out_item_next.bearing = '0;
        else if (z_round > c2p_pkg::Z_W'(c2p_pkg::BEARING_MAX))
            out_item_next.bearing = 16'(c2p_pkg::BEARING_MAX);
        else if (z_round < -c2p_pkg::Z_W'(c2p_pkg::BEARING_MAX))
            out_item_next.bearing = -16'(c2p_pkg::BEARING_MAX);
        else
            out_item_next.bearing = z_round[15:0];
        out_item_next.rate_saturated = 1'b0;
        if (d_data[ND].neg)
        begin
            if (q > c2p_pkg::QUOT_W'(34'h080000000))
            begin
                out_item_next.range_rate     = 32'sh80000000;
                out_item_next.rate_saturated = 1'b1;
            end
            else
            begin
                out_item_next.range_rate = -q[31:0];
            end
        end
        else
        begin
            if (q > c2p_pkg::QUOT_W'(34'h07FFFFFFF))
            begin
                out_item_next.range_rate     = 32'sh7FFFFFFF;
                out_item_next.rate_saturated = 1'b1;
            end
            else
            begin
                out_item_next.range_rate = q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= d_valid[ND];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.bearing <= 16'sd25736) && (out_item.bearing >= -16'sd25736))
        else $error("bearing outside its range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.rate_saturated |->
            (out_item.range_rate == 32'sh7FFFFFFF) || (out_item.range_rate == 32'sh80000000))
        else $error("saturated range rate not at a limit");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> min_range_reg == $past(cfg_data))
        else $error("min_range write lost");
`endif

endmodule

`default_nettype wire
